// ===== sv/pngu_pkg.sv =====
`timescale 1ns / 1ps
// pngu_pkg: shared types, register indexes and filter classes for the PNG unfilter core.
// No dependencies. Every module of the core imports it.
package pngu_pkg;

    localparam int ROW_BYTES_W  = 14;
    localparam int STRIDE_W     = 4;
    localparam int STRIDE_SEL_W = 3;
    localparam int HIST_DEPTH   = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 14;

    typedef logic [7:0]           t_byte;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_ROW_BYTES    = t_cfg_idx'(0);
    localparam t_cfg_idx REG_PIXEL_STRIDE = t_cfg_idx'(1);

    // Filter class of a row; every type code above Paeth folds into FILT_BAD.
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4,
        FILT_BAD   = 3'd5
    } t_filt;

    // One classified stream byte as it travels from front to back.
    typedef struct packed {
        logic  is_data;
        logic  last;
        logic  first_row;
        t_filt filt;
        t_byte data;
    } t_cls;

    function automatic t_filt classify(input t_byte b);
        if (b > 8'd4) begin
            return FILT_BAD;
        end
        return t_filt'(b[2:0]);
    endfunction

endpackage

// ===== sv/pngu_front.sv =====
`timescale 1ns / 1ps
// pngu_front: scanline tracker. Classifies each stream byte (type or data), tags it
// with its column index, row end and first-row flag. Depends on pngu_pkg.
module pngu_front
    import pngu_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 8192,
    parameter int IW            = $clog2(MAX_ROW_BYTES)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  t_byte                  i_data_byte,
    input  logic                   i_pass_start,
    input  logic [ROW_BYTES_W-1:0] i_row_bytes,
    output t_cls                   o_cls,
    output logic [IW-1:0]          o_idx
);

    localparam int CW = $clog2(MAX_ROW_BYTES + 1);
    localparam int LW = (CW > ROW_BYTES_W) ? CW : ROW_BYTES_W;

    logic [CW-1:0] r_column, n_column;
    t_filt         r_filt, n_filt;
    logic          r_first, n_first;

    logic [LW-1:0] rb_ext;
    logic [LW-1:0] len;
    logic [CW-1:0] col_m1;
    logic          is_data;
    logic          last;

    // effective row length: zero acts as one, clamp at the row store depth
    always_comb begin
        rb_ext = LW'(i_row_bytes);
        if (rb_ext == '0) begin
            len = LW'(1);
        end else if (rb_ext > LW'(MAX_ROW_BYTES)) begin
            len = LW'(MAX_ROW_BYTES);
        end else begin
            len = rb_ext;
        end
    end

    assign is_data = (r_column != '0);
    assign last    = is_data && (LW'(r_column) >= len);
    assign col_m1  = r_column - CW'(1);

    always_comb begin
        o_cls.is_data   = is_data;
        o_cls.last      = last;
        o_cls.first_row = r_first;
        o_cls.filt      = is_data ? r_filt : classify(i_data_byte);
        o_cls.data      = i_data_byte;
        o_idx           = col_m1[IW-1:0];
    end

    always_comb begin
        n_column = r_column;
        n_filt   = r_filt;
        n_first  = r_first;
        if (i_accept) begin
            if (!is_data) begin
                n_filt   = classify(i_data_byte);
                n_first  = r_first | i_pass_start;
                n_column = CW'(1);
            end else if (last) begin
                n_column = '0;
                n_first  = 1'b0;
            end else begin
                n_column = r_column + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_filt   <= FILT_NONE;
            r_first  <= 1'b1;
        end else begin
            r_column <= n_column;
            r_filt   <= n_filt;
            r_first  <= n_first;
        end
    end

endmodule

// ===== sv/pngu_queue.sv =====
`timescale 1ns / 1ps
// pngu_queue: small FIFO that decouples the front tracker from the back datapath.
// Depends on pngu_pkg only for the common house import.
module pngu_queue
    import pngu_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [NW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (do_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + NW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count exceeds depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wp == r_rp))
        else $error("empty queue with unequal pointers");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == $past(r_count) - NW'(1)))
        else $error("pop did not shrink queue");

endmodule

// ===== sv/pngu_back.sv =====
`timescale 1ns / 1ps
// pngu_back: reconstruction datapath. Row store read, left/upper-left history,
// None/Sub/Up/Average/Paeth predictor and the output register. Depends on pngu_pkg.
module pngu_back
    import pngu_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 8192,
    parameter int IW            = $clog2(MAX_ROW_BYTES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_cls                i_q_cls,
    input  logic [IW-1:0]       i_q_idx,
    output logic                o_pop,
    input  logic [STRIDE_W-1:0] i_pixel_stride,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_byte               o_value,
    output logic                o_is_data,
    output logic                o_row_end,
    output logic                o_bad_filter
);

    t_byte         r_mem [MAX_ROW_BYTES];
    t_byte         r_rd_data;

    logic          r_s1_vld;
    t_cls          r_s1_cls;
    logic [IW-1:0] r_s1_idx;

    t_byte         r_left   [HIST_DEPTH];
    t_byte         r_upleft [HIST_DEPTH];

    logic          r_out_vld;
    t_byte         r_out_value;
    logic          r_out_is_data;
    logic          r_out_row_end;
    logic          r_out_bad;

    logic                    ld_out;
    logic                    s1_take;
    logic [STRIDE_SEL_W-1:0] sel;
    t_byte                   left, above, upleft, pred, val;
    logic signed [9:0]       pa, pb, pc;
    logic [8:0]              avg_sum;

    assign ld_out  = r_s1_vld && (!r_out_vld || i_out_ready);
    assign s1_take = !r_s1_vld || ld_out;
    assign o_pop   = i_q_valid && s1_take;

    // stride to history tap: zero acts as one, above eight acts as eight
    always_comb begin
        if (i_pixel_stride == '0) begin
            sel = '0;
        end else if (i_pixel_stride > STRIDE_W'(HIST_DEPTH)) begin
            sel = STRIDE_SEL_W'(HIST_DEPTH - 1);
        end else begin
            sel = STRIDE_SEL_W'(i_pixel_stride - STRIDE_W'(1));
        end
    end

    always_comb begin
        left    = r_left[sel];
        upleft  = r_upleft[sel];
        above   = r_s1_cls.first_row ? 8'd0 : r_rd_data;
        avg_sum = {1'b0, left} + {1'b0, above};
        // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
        pa = $signed({2'b00, above}) - $signed({2'b00, upleft});
        pb = $signed({2'b00, left}) - $signed({2'b00, upleft});
        pc = pa + pb;
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        case (r_s1_cls.filt)
            FILT_NONE:  pred = 8'd0;
            FILT_SUB:   pred = left;
            FILT_UP:    pred = above;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: begin
                if (pa <= pb && pa <= pc) begin
                    pred = left;
                end else if (pb <= pc) begin
                    pred = above;
                end else begin
                    pred = upleft;
                end
            end
            FILT_BAD:   pred = 8'd0;
            default:    pred = 8'd0;
        endcase
        val = r_s1_cls.data + pred;
    end

    // row store: read as the item enters stage 1, written as it leaves
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_mem[i_q_idx];
        end
        if (ld_out && r_s1_cls.is_data) begin
            r_mem[r_s1_idx] <= val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_cls <= i_q_cls;
            r_s1_idx <= i_q_idx;
        end
        if (ld_out) begin
            r_out_value   <= r_s1_cls.is_data ? val : 8'd0;
            r_out_is_data <= r_s1_cls.is_data;
            r_out_row_end <= r_s1_cls.is_data && r_s1_cls.last;
            r_out_bad     <= (r_s1_cls.filt == FILT_BAD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_left[i]   <= 8'd0;
                r_upleft[i] <= 8'd0;
            end
        end else begin
            if (s1_take) begin
                r_s1_vld <= i_q_valid;
            end
            if (ld_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (ld_out) begin
                if (!r_s1_cls.is_data) begin
                    for (int i = 0; i < HIST_DEPTH; i++) begin
                        r_left[i]   <= 8'd0;
                        r_upleft[i] <= 8'd0;
                    end
                end else begin
                    r_left[0]   <= val;
                    r_upleft[0] <= above;
                    for (int i = 1; i < HIST_DEPTH; i++) begin
                        r_left[i]   <= r_left[i-1];
                        r_upleft[i] <= r_upleft[i-1];
                    end
                end
            end
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_value      = r_out_value;
    assign o_is_data    = r_out_is_data;
    assign o_row_end    = r_out_row_end;
    assign o_bad_filter = r_out_bad;

    a_type_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_out && !r_s1_cls.is_data) |=> (r_out_value == 8'd0 && !r_out_row_end))
        else $error("filter-type result carries data");

    a_none_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_out && r_s1_cls.is_data && (r_s1_cls.filt == FILT_NONE || r_s1_cls.filt == FILT_BAD))
        |=> (r_out_value == $past(r_s1_cls.data)))
        else $error("unpredicted byte altered");

    a_hist_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_out && !r_s1_cls.is_data) |=> (r_left[0] == 8'd0 && r_upleft[HIST_DEPTH-1] == 8'd0))
        else $error("history not cleared at row start");

endmodule

// ===== sv/png_scanline_unfilter_core.sv =====
`timescale 1ns / 1ps
// png_scanline_unfilter_core: top level of the PNG scanline unfilter.
// Instantiates pngu_front, pngu_queue and pngu_back; depends on pngu_pkg.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | sink      | i_in_valid / o_in_ready    | i_data_byte, i_pass_start
//  out     | source    | o_out_valid / i_out_ready  | o_value, o_is_data, o_row_end,
//          |           |                            | o_bad_filter
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  Throughput: one byte per cycle, sustained while i_out_ready is high, with a result for every byte.
//  Path: from input transfer to output valid an item passes the queue entry,
//  then the row store read stage, then the output register.
//  The row store is a single-port-read, single-port-write memory of
//  MAX_ROW_BYTES bytes; one read and one write per cycle set the rate.
//  Reset: synchronous, active low; control and history clear at once, no
//  clearing pass. Row store contents are undefined until written.
//  Stalls: the output register holds while i_out_ready is low; the
//  two-entry queue keeps o_in_ready high until it fills. cfg is always ready.
module png_scanline_unfilter_core
    import pngu_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 8192
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_pass_start,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_value,
    output logic                  o_is_data,
    output logic                  o_row_end,
    output logic                  o_bad_filter,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW      = $clog2(MAX_ROW_BYTES);
    localparam int Q_DEPTH = 2;
    localparam int Q_W     = $bits(t_cls) + IW;

    // configuration registers
    logic [ROW_BYTES_W-1:0] r_row_bytes;
    logic [STRIDE_W-1:0]    r_pixel_stride;

    // front to queue
    t_cls          f_cls;
    logic [IW-1:0] f_idx;
    logic          q_full;
    logic          in_xfer;

    // queue to back
    logic          q_valid;
    logic          q_pop;
    logic [Q_W-1:0] q_rdata;
    t_cls          b_cls;
    logic [IW-1:0] b_idx;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes    <= ROW_BYTES_W'(1);
            r_pixel_stride <= STRIDE_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROW_BYTES:    r_row_bytes    <= i_cfg_data[ROW_BYTES_W-1:0];
                REG_PIXEL_STRIDE: r_pixel_stride <= i_cfg_data[STRIDE_W-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // the front is ready whenever the queue has room
    assign o_in_ready = !q_full;
    assign in_xfer    = i_in_valid && o_in_ready;

    pngu_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .IW            (IW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_xfer),
        .i_data_byte  (i_data_byte),
        .i_pass_start (i_pass_start),
        .i_row_bytes  (r_row_bytes),
        .o_cls        (f_cls),
        .o_idx        (f_idx)
    );

    pngu_queue #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_wdata ({f_idx, f_cls}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_rdata (q_rdata)
    );

    assign b_cls = t_cls'(q_rdata[$bits(t_cls)-1:0]);
    assign b_idx = q_rdata[Q_W-1:$bits(t_cls)];

    pngu_back #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .IW            (IW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_cls        (b_cls),
        .i_q_idx        (b_idx),
        .o_pop          (q_pop),
        .i_pixel_stride (r_pixel_stride),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_value        (o_value),
        .o_is_data      (o_is_data),
        .o_row_end      (o_row_end),
        .o_bad_filter   (o_bad_filter)
    );

endmodule

// ===== test/png_scanline_unfilter_core_tb.sv =====
`timescale 1ns / 1ps
// png_scanline_unfilter_core_tb: self-checking bench for the PNG scanline unfilter core.
// Carries its own row reconstruction model; depends on pngu_pkg and png_scanline_unfilter_core.
module png_scanline_unfilter_core_tb;
    import pngu_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int ROW_STORE_DEPTH = 8192;
    localparam int RANDOM_BYTES    = 2000;
    localparam int MAX_REPORTS     = 10;
    // Drain time after the final settle, before the verdict.
    localparam int DRAIN_CYCLES    = 8;
    localparam int TIMEOUT_CYCLES  = 1000000;

    // Index values the core decodes to nothing; writes there must change no behavior.
    localparam t_cfg_idx REG_SPARE_2 = t_cfg_idx'(2);
    localparam t_cfg_idx REG_SPARE_3 = t_cfg_idx'(3);
    // Largest filter-type byte, the far end of the unknown-type range.
    localparam t_byte FILTER_TYPE_MAX = 8'hFF;

    // One output transfer, field by field.
    typedef struct packed {
        t_byte value;
        logic  is_data;
        logic  row_end;
        logic  bad_filter;
    } t_recon;

    // ------------------------------------------------------------------
    // Row reconstruction model. Mirrors the core's state (row store,
    // left and upper-left history, column, row filter, first-row flag,
    // both registers) and keeps the reconstructed bytes still owed by
    // the core in arrival order.
    // ------------------------------------------------------------------
    class unfilter_model;
        t_byte                  row_store [ROW_STORE_DEPTH];
        int                     stored;       // row store entries written, always a prefix
        logic [63:0]            left_hist;
        logic [63:0]            upleft_hist;
        int                     col;          // 0 while a filter-type byte is due
        t_byte                  row_filter;
        bit                     first_row;
        logic [ROW_BYTES_W-1:0] row_len_reg;
        logic [STRIDE_W-1:0]    stride_reg;
        t_recon                 pending_recon[$];
        int                     mismatches;
        int                     results;
        int                     bytes_in;
        int                     rows;
        int                     bad_rows;
        int                     reg_writes;
        int                     filt_rows [5];

        function new();
            stored      = 0;
            left_hist   = '0;
            upleft_hist = '0;
            col         = 0;
            row_filter  = '0;
            first_row   = 1'b1;
            row_len_reg = ROW_BYTES_W'(1);
            stride_reg  = STRIDE_W'(1);
            mismatches  = 0;
            results     = 0;
            bytes_in    = 0;
            rows        = 0;
            bad_rows    = 0;
            reg_writes  = 0;
            foreach (filt_rows[i]) filt_rows[i] = 0;
        endfunction

        function int clamp_len(int v);
            if (v == 0) return 1;
            if (v > ROW_STORE_DEPTH) return ROW_STORE_DEPTH;
            return v;
        endfunction

        function int row_len();
            return clamp_len(int'(row_len_reg));
        endfunction

        function int stride();
            if (stride_reg == 0) return 1;
            if (stride_reg > 8) return 8;
            return int'(stride_reg);
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            if (idx == REG_ROW_BYTES) begin
                row_len_reg = data[ROW_BYTES_W-1:0];
            end else if (idx == REG_PIXEL_STRIDE) begin
                stride_reg = data[STRIDE_W-1:0];
            end
        endfunction

        // Paeth predictor; ties go to left, then above.
        function t_byte paeth_pick(t_byte a, t_byte b, t_byte c);
            int p;
            int da;
            int db;
            int dc;
            p  = int'(a) + int'(b) - int'(c);
            da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
            db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
            dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
            if (da <= db && da <= dc) return a;
            if (db <= dc) return b;
            return c;
        endfunction

        // Accepted input byte: advance the model and queue the result it owes.
        function void take_byte(t_byte b, logic start);
            t_recon r;
            t_byte  left;
            t_byte  upleft;
            t_byte  above;
            t_byte  pred;
            int     idx;
            int     sh;
            bit     last;
            bytes_in++;
            if (col == 0) begin
                row_filter  = b;
                if (start) first_row = 1'b1;
                left_hist   = '0;
                upleft_hist = '0;
                col         = 1;
                rows++;
                if (b > t_byte'(FILT_PAETH)) begin
                    bad_rows++;
                end else begin
                    filt_rows[int'(b)]++;
                end
                r = '{value: 8'h00, is_data: 1'b0, row_end: 1'b0,
                      bad_filter: (b > t_byte'(FILT_PAETH))};
                pending_recon.push_back(r);
                return;
            end
            idx    = col - 1;
            sh     = (stride() - 1) * 8;
            left   = t_byte'(left_hist >> sh);
            upleft = t_byte'(upleft_hist >> sh);
            above  = first_row ? 8'h00 : row_store[idx];
            pred   = 8'h00;
            r.bad_filter = 1'b0;
            if (row_filter > t_byte'(FILT_PAETH)) begin
                r.bad_filter = 1'b1;
            end else begin
                case (t_filt'(row_filter[2:0]))
                    FILT_SUB:   pred = left;
                    FILT_UP:    pred = above;
                    FILT_AVG:   pred = t_byte'((9'(left) + 9'(above)) >> 1);
                    FILT_PAETH: pred = paeth_pick(left, above, upleft);
                    default:    pred = 8'h00;
                endcase
            end
            r.value = b + pred;
            row_store[idx] = r.value;
            if (idx + 1 > stored) stored = idx + 1;
            left_hist   = {left_hist[55:0], r.value};
            upleft_hist = {upleft_hist[55:0], above};
            // A mid-row shrink of row_bytes can leave col past the new length.
            last = (col >= row_len());
            if (last) begin
                col       = 0;
                first_row = 1'b0;
            end else begin
                col++;
            end
            r.is_data = 1'b1;
            r.row_end = last;
            pending_recon.push_back(r);
        endfunction

        // Output transfer: compare against the oldest owed result.
        function void check_result(t_recon got);
            t_recon want;
            results++;
            if (pending_recon.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] result with nothing owed: value=%02h data=%0b end=%0b bad=%0b",
                             $time, got.value, got.is_data, got.row_end, got.bad_filter);
                end
                return;
            end
            want = pending_recon.pop_front();
            if (want !== got) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] result %0d: expected value=%02h data=%0b end=%0b bad=%0b",
                             $time, results, want.value, want.is_data, want.row_end,
                             want.bad_filter);
                    $display("           got      value=%02h data=%0b end=%0b bad=%0b",
                             got.value, got.is_data, got.row_end, got.bad_filter);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_data_byte;
    logic                  i_pass_start;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [7:0]            o_value;
    logic                  o_is_data;
    logic                  o_row_end;
    logic                  o_bad_filter;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    unfilter_model recon = new();
    // Set for a stretch of phases: neither side idles while it is high.
    bit calm = 1'b0;

    png_scanline_unfilter_core #(
        .MAX_ROW_BYTES (ROW_STORE_DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_pass_start (i_pass_start),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_value      (o_value),
        .o_is_data    (o_is_data),
        .o_row_end    (o_row_end),
        .o_bad_filter (o_bad_filter),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the core hangs on a handshake.
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("simulation failed");
        $finish;
    end

    // Output side: check each transfer seen at this edge, then pick the next
    // ready value (about one cycle in five stalls outside calm phases).
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            recon.check_result(t_recon'{o_value, o_is_data, o_row_end, o_bad_filter});
        end
        i_out_ready <= calm || ($urandom_range(99) >= 20);
    end

    // Biased data bytes: a quarter come from a few edge values, which makes
    // Paeth ties and wrap-around sums far more frequent than pure random.
    function automatic t_byte pick_data();
        if ($urandom_range(99) < 25) begin
            case ($urandom_range(3))
                0:       return 8'h00;
                1:       return 8'h01;
                2:       return 8'h80;
                default: return 8'hFF;
            endcase
        end
        return t_byte'($urandom_range(255));
    endfunction

    // One input transfer, with a random idle gap in front of it. Valid only
    // drops when a gap is taken, so back-to-back bytes keep it high.
    task automatic push_byte(input t_byte b, input logic start);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < 20) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_pass_start <= start;
        do @(posedge i_clk); while (!o_in_ready);
        recon.take_byte(b, start);
    endtask

    // One config transfer; the caller drops i_cfg_valid after the last write.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        recon.write_reg(idx, data);
    endtask

    // Stop the input side and wait until every owed result has come back.
    // Every byte yields a result, so an empty queue means the core is idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (recon.pending_recon.size() != 0);
    endtask

    // Well-formed rows with random content. A row that would read row store
    // entries never written gets a forced pass start. With cut set, the last
    // row stops somewhere before its end, leaving the core mid-row.
    task automatic send_rows(input int nrows, input bit cut);
        t_byte filt;
        logic  start;
        int    remaining;
        int    k;
        for (int r = 0; r < nrows; r++) begin
            if (recon.col == 0) begin
                if ($urandom_range(99) < 12) begin
                    filt = t_byte'($urandom_range(255, int'(FILT_BAD)));
                end else begin
                    filt = t_byte'($urandom_range(int'(FILT_PAETH)));
                end
                start = ($urandom_range(99) < 15);
                if (!start && !recon.first_row && recon.row_len() > recon.stored) begin
                    start = 1'b1;
                end
                push_byte(filt, start);
            end
            if (cut && r == nrows - 1) begin
                remaining = recon.row_len() - recon.col + 1;
                if (remaining < 1) remaining = 1;
                k = $urandom_range(remaining - 1);
                repeat (k) push_byte(pick_data(), $urandom_range(99) < 5);
            end else begin
                do push_byte(pick_data(), $urandom_range(99) < 5); while (recon.col != 0);
            end
        end
    endtask

    initial begin
        int phase;
        int small_bytes;
        int before_bytes;
        int len;
        int stride_sel;
        int stride_data;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_data_byte  <= 8'h00;
        i_pass_start <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= REG_ROW_BYTES;
        i_cfg_data   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---------------- directed part ----------------
        // Reset registers (one byte per row, stride one): None then Sub.
        push_byte(t_byte'(FILT_NONE), 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(t_byte'(FILT_SUB), 1'b1);
        push_byte(8'hFF, 1'b0);

        // Zero row length and zero stride both act as one; Up wraps 0xFF + 0x80.
        settle();
        write_reg(REG_ROW_BYTES, CFG_DATA_W'(0));
        write_reg(REG_PIXEL_STRIDE, CFG_DATA_W'(0));
        i_cfg_valid <= 1'b0;
        push_byte(t_byte'(FILT_UP), 1'b0);
        push_byte(8'h80, 1'b0);

        // Longer row needs a new pass; stride above eight with all data bits set.
        settle();
        write_reg(REG_ROW_BYTES, CFG_DATA_W'(4));
        write_reg(REG_PIXEL_STRIDE, '1);
        i_cfg_valid <= 1'b0;
        push_byte(t_byte'(FILT_AVG), 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h7F, 1'b0);

        // Paeth over the previous row, stride one.
        settle();
        write_reg(REG_PIXEL_STRIDE, CFG_DATA_W'(1));
        i_cfg_valid <= 1'b0;
        push_byte(t_byte'(FILT_PAETH), 1'b0);
        push_byte(8'h10, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h00, 1'b0);

        // Largest filter type; pass start on a data byte must be ignored.
        // Writes to the two undecoded indexes go in here too.
        settle();
        write_reg(REG_PIXEL_STRIDE, CFG_DATA_W'(8));
        write_reg(REG_SPARE_2, CFG_DATA_W'('h2AAA));
        write_reg(REG_SPARE_3, CFG_DATA_W'('h1555));
        i_cfg_valid <= 1'b0;
        push_byte(FILTER_TYPE_MAX, 1'b0);
        push_byte(8'h12, 1'b1);
        push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b0);
        push_byte(8'h78, 1'b0);

        // Smallest unknown type, then shrink the row length mid-row: the column
        // is already past the new length, so the next byte closes the row.
        settle();
        write_reg(REG_ROW_BYTES, CFG_DATA_W'(8));
        i_cfg_valid <= 1'b0;
        push_byte(t_byte'(FILT_BAD), 1'b1);
        push_byte(8'hAB, 1'b0);
        push_byte(8'hCD, 1'b0);
        push_byte(8'hEF, 1'b0);
        settle();
        write_reg(REG_ROW_BYTES, CFG_DATA_W'(2));
        i_cfg_valid <= 1'b0;
        push_byte(8'h11, 1'b0);

        // ---------------- random part ----------------
        // Each phase: fresh registers while idle, then a few rows. Phases
        // 8 to 12 run with no idling on either side.
        phase       = 0;
        small_bytes = 0;
        while (small_bytes < RANDOM_BYTES) begin
            settle();
            calm = (phase >= 8 && phase < 13);

            if ($urandom_range(99) < 8) begin
                len = 0;
            end else if ($urandom_range(99) < 10) begin
                len = $urandom_range(96, 25);
            end else begin
                len = $urandom_range(24, 1);
            end
            // Growing a row already in progress must not reach unwritten entries.
            if (recon.col != 0 && !recon.first_row && recon.clamp_len(len) > recon.stored) begin
                len = recon.stored;
            end
            stride_sel  = $urandom_range(15);
            stride_data = ($urandom_range(1023) << STRIDE_W) | stride_sel;

            if ($urandom_range(1)) begin
                write_reg(REG_ROW_BYTES, CFG_DATA_W'(len));
                write_reg(REG_PIXEL_STRIDE, CFG_DATA_W'(stride_data));
            end else begin
                write_reg(REG_PIXEL_STRIDE, CFG_DATA_W'(stride_data));
                write_reg(REG_ROW_BYTES, CFG_DATA_W'(len));
            end
            if ($urandom_range(99) < 20) begin
                write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_DATA_W'($urandom_range((1 << CFG_DATA_W) - 1)));
            end
            i_cfg_valid <= 1'b0;

            before_bytes = recon.bytes_in;
            send_rows($urandom_range(6, 1), $urandom_range(99) < 15);
            small_bytes += recon.bytes_in - before_bytes;
            phase++;
        end

        settle();
        calm = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d stream bytes in %0d rows (%0d with unknown filter types), %0d phases",
                 recon.bytes_in, recon.rows, recon.bad_rows, phase);
        $display("%0d register writes; rows by filter none/sub/up/avg/paeth: %0d/%0d/%0d/%0d/%0d",
                 recon.reg_writes, recon.filt_rows[0], recon.filt_rows[1], recon.filt_rows[2],
                 recon.filt_rows[3], recon.filt_rows[4]);
        if (recon.mismatches == 0 && recon.pending_recon.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results still owed", recon.mismatches,
                     recon.pending_recon.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
